FILE: rtl/mltb_pkg.sv
// ----------------------------------------------------------------------------
// mltb_pkg
// Shared types and codes of the timed LED bank controller.
// ----------------------------------------------------------------------------
package mltb_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_OFF   = 2'd1,
        ACT_ON    = 2'd2,
        ACT_FLASH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_FLASH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_RANGE       = 2'd1,
        ST_ZERO_PERIOD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV1,
        S_CONV2,
        S_APPLY,
        S_PASS_GO,
        S_PASS_RUN,
        S_OUT
    } t_state;

    localparam logic [7:0] CFG_LEDS_IN_USE   = 8'd0;
    localparam logic [7:0] CFG_ACTIVE_HIGH   = 8'd1;
    localparam logic [7:0] ACTIVE_HIGH_RESET = 8'hFF;

    // command written into one cell
    typedef struct packed {
        t_mode       mode;
        logic [15:0] rem;
        logic [15:0] on_t;
        logic [15:0] off_t;
    } t_cmd;

endpackage

FILE: rtl/mltb_ms2tk.sv
// ----------------------------------------------------------------------------
// mltb_ms2tk
// Milliseconds to ticks: two-stage divide by the timebase constant using a
// reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module mltb_ms2tk import mltb_pkg::*; #(
    parameter int TIMEBASE_MS = 10
) (
    input  logic        i_clk,
    input  logic [15:0] i_ms,
    output logic [15:0] o_ticks
);

    localparam int         SH    = 26;
    localparam int         MW    = 27;
    localparam int         DW    = 10;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / TIMEBASE_MS);
    localparam logic [DW-1:0] TB    = DW'(TIMEBASE_MS);

    logic [41:0] r_prod;
    logic [15:0] r_ms;
    logic [15:0] w_q0;
    logic [25:0] w_qd;
    logic [16:0] w_rem;

    always_ff @(posedge i_clk) begin
        r_prod <= i_ms * RECIP;
        r_ms   <= i_ms;
    end

    // q0 is the true quotient or one below it
    assign w_q0  = r_prod[41:26];
    assign w_qd  = w_q0 * TB;
    assign w_rem = {1'b0, r_ms} - w_qd[16:0];

    always_ff @(posedge i_clk) begin
        if (w_rem >= 17'(TIMEBASE_MS)) begin
            o_ticks <= w_q0 + 16'd1;
        end else begin
            o_ticks <= w_q0;
        end
    end

endmodule

FILE: rtl/mltb_cell.sv
// ----------------------------------------------------------------------------
// mltb_cell
// State of one LED. Steps its timers when the pass token reaches it and
// hands the token and the needs-ticks flag to the next cell.
// ----------------------------------------------------------------------------
module mltb_cell import mltb_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_count,
    input  logic       i_tok,
    input  logic       i_need,
    input  logic       i_wr,
    input  t_cmd       i_cmd,
    output logic       o_tok,
    output logic       o_need,
    output logic       o_lit
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_on, n_on;
    logic [15:0] r_off, n_off;
    logic [15:0] r_pc, n_pc;
    logic        r_phase, n_phase;
    logic        r_lit, n_lit;
    logic        r_tok;
    logic        r_need;
    logic        w_managed;
    logic        w_step_need;
    logic [15:0] w_rem_dec;
    logic [15:0] w_pc_dec;

    assign w_managed = 32'(IDX) < 32'(i_count);
    assign w_rem_dec = r_rem - 16'd1;
    assign w_pc_dec  = r_pc - 16'd1;

    always_comb begin
        n_mode      = r_mode;
        n_rem       = r_rem;
        n_on        = r_on;
        n_off       = r_off;
        n_pc        = r_pc;
        n_phase     = r_phase;
        n_lit       = r_lit;
        w_step_need = 1'b0;
        if (i_wr) begin
            case (i_cmd.mode)
                MODE_OFF: begin
                    n_mode = MODE_OFF;
                    n_lit  = 1'b0;
                end
                MODE_ON: begin
                    n_mode = MODE_ON;
                    n_rem  = i_cmd.rem;
                    n_lit  = 1'b1;
                end
                MODE_FLASH: begin
                    n_mode  = MODE_FLASH;
                    n_rem   = i_cmd.rem;
                    n_on    = i_cmd.on_t;
                    n_off   = i_cmd.off_t;
                    n_phase = 1'b1;
                    n_pc    = i_cmd.on_t;
                    n_lit   = 1'b1;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end else if (i_tok && w_managed && r_mode != MODE_OFF
                     && !(r_mode == MODE_ON && r_rem == 16'd0)) begin
            if (r_rem != 16'd0 && w_rem_dec == 16'd0) begin
                // active time ran out
                n_rem  = w_rem_dec;
                n_mode = MODE_OFF;
                n_lit  = 1'b0;
            end else begin
                w_step_need = 1'b1;
                if (r_rem != 16'd0) begin
                    n_rem = w_rem_dec;
                end
                if (r_mode == MODE_FLASH) begin
                    n_pc = w_pc_dec;
                    if (w_pc_dec == 16'd0) begin
                        n_phase = ~r_phase;
                        n_lit   = ~r_phase;
                        n_pc    = r_phase ? r_off : r_on;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_rem   <= '0;
            r_on    <= '0;
            r_off   <= '0;
            r_pc    <= '0;
            r_phase <= 1'b0;
            r_lit   <= 1'b0;
            r_tok   <= 1'b0;
            r_need  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_rem   <= n_rem;
            r_on    <= n_on;
            r_off   <= n_off;
            r_pc    <= n_pc;
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_tok   <= i_tok;
            r_need  <= i_need | w_step_need;
        end
    end

    assign o_tok  = r_tok;
    assign o_need = r_need;
    assign o_lit  = r_lit;

endmodule

FILE: rtl/multi_led_timed_blink_controller_unit.sv
// ----------------------------------------------------------------------------
// multi_led_timed_blink_controller_unit
// Timed LED bank controller: off, on and flash commands per LED, timebase
// ticks that count down active and phase times in a chain of LED cells.
//
//   channel  | direction | beat contents
//   ---------+-----------+-----------------------------------------------
//   s_axis   | in        | tuser action; tdata led, active/on/off ms
//   m_axis   | out       | tuser status; tdata pin levels, busy
//   cfg      | in        | index 0 leds_in_use, index 1 active_high_mask
//
// A tick with the ticker idle goes straight to the result; a tick pass walks
// the token down the cell chain one LED per cycle.
// A command steps through S_CONV1, S_CONV2 (two-stage ms to tick conversion)
// and S_APPLY, then a pass if it starts the ticker; a rejected one skips them.
// Reset is synchronous; all LEDs go dark and the ticker stops.
// A result waiting on m_axis_tready holds the block before its next beat.
// ----------------------------------------------------------------------------
module multi_led_timed_blink_controller_unit import mltb_pkg::*; #(
    parameter int NUM_LEDS    = 8,
    parameter int TIMEBASE_MS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] led, [23:8] active_ms, [39:24] flash_on_ms, [55:40] flash_off_ms
    input  logic [55:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] pin_levels, [8] busy_res, [15:9] zero
    output logic [15:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_state      r_state, n_state;
    t_action     r_action;
    logic [7:0]  r_led;
    logic [15:0] r_act_ms;
    logic [15:0] r_on_ms;
    logic [15:0] r_off_ms;
    t_status     r_status, n_status;
    logic        r_running, n_running;
    logic [3:0]  r_leds_in_use;
    logic [7:0]  r_mask;
    logic        r_m_valid;
    logic [7:0]  r_m_pins;
    t_status     r_m_status;
    logic        r_m_busy;

    logic [3:0]  w_count;
    logic        w_accept;
    logic        w_apply;
    logic        w_tok0;
    logic        w_load_out;
    t_action     w_in_action;
    logic [15:0] w_act_t;
    logic [15:0] w_on_raw;
    logic [15:0] w_off_raw;
    t_cmd        w_cmd;
    logic [7:0]  w_pins;

    logic [NUM_LEDS:0]   w_tok;
    logic [NUM_LEDS:0]   w_need;
    logic [NUM_LEDS-1:0] w_lit;

    assign w_count = (32'(r_leds_in_use) < NUM_LEDS) ? r_leds_in_use : 4'(NUM_LEDS);
    assign w_in_action = t_action'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leds_in_use <= '0;
            r_mask        <= ACTIVE_HIGH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LEDS_IN_USE) begin
                r_leds_in_use <= i_cfg_data[3:0];
            end else if (i_cfg_index == CFG_ACTIVE_HIGH) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= w_in_action;
            r_led    <= s_axis_tdata[7:0];
            r_act_ms <= s_axis_tdata[23:8];
            r_on_ms  <= s_axis_tdata[39:24];
            r_off_ms <= s_axis_tdata[55:40];
        end
    end

    mltb_ms2tk #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_act (
        .i_clk   (i_clk),
        .i_ms    (r_act_ms),
        .o_ticks (w_act_t)
    );

    mltb_ms2tk #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_on (
        .i_clk   (i_clk),
        .i_ms    (r_on_ms),
        .o_ticks (w_on_raw)
    );

    mltb_ms2tk #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_off (
        .i_clk   (i_clk),
        .i_ms    (r_off_ms),
        .o_ticks (w_off_raw)
    );

    always_comb begin
        case (r_action)
            ACT_ON:    w_cmd.mode = MODE_ON;
            ACT_FLASH: w_cmd.mode = MODE_FLASH;
            default:   w_cmd.mode = MODE_OFF;
        endcase
        w_cmd.rem = w_act_t;
        // periods below one tick are raised to one tick
        w_cmd.on_t  = (w_on_raw == 16'd0) ? 16'd1 : w_on_raw;
        w_cmd.off_t = (w_off_raw == 16'd0) ? 16'd1 : w_off_raw;
    end

    assign w_tok[0]  = w_tok0;
    assign w_need[0] = 1'b0;

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_cell
        mltb_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (w_count),
            .i_tok   (w_tok[g]),
            .i_need  (w_need[g]),
            .i_wr    (w_apply && r_led == 8'(g)),
            .i_cmd   (w_cmd),
            .o_tok   (w_tok[g+1]),
            .o_need  (w_need[g+1]),
            .o_lit   (w_lit[g])
        );
    end

    for (genvar p = 0; p < 8; p++) begin : g_pin
        if (p < NUM_LEDS) begin : g_used
            assign w_pins[p] = ~(w_lit[p] ^ r_mask[p]);
        end else begin : g_none
            assign w_pins[p] = 1'b0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_running  = r_running;
        w_apply    = 1'b0;
        w_tok0     = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    if (w_in_action == ACT_TICK) begin
                        n_state = r_running ? S_PASS_GO : S_OUT;
                    end else if (s_axis_tdata[7:0] >= {4'd0, w_count}) begin
                        n_status = ST_RANGE;
                        n_state  = S_OUT;
                    end else if (w_in_action == ACT_FLASH && (s_axis_tdata[39:24] == 16'd0
                                 || s_axis_tdata[55:40] == 16'd0)) begin
                        n_status = ST_ZERO_PERIOD;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_CONV1;
                    end
                end
            end
            S_CONV1: n_state = S_CONV2;
            S_CONV2: n_state = S_APPLY;
            S_APPLY: begin
                w_apply = 1'b1;
                if (!r_running && (r_action == ACT_FLASH
                                   || (r_action == ACT_ON && r_act_ms != 16'd0))) begin
                    n_running = 1'b1;
                    n_state   = S_PASS_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PASS_GO: begin
                w_tok0  = 1'b1;
                n_state = S_PASS_RUN;
            end
            S_PASS_RUN: begin
                if (w_tok[NUM_LEDS]) begin
                    n_running = w_need[NUM_LEDS];
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= ST_OK;
            r_running <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_running <= n_running;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_pins   <= w_pins;
            r_m_status <= r_status;
            r_m_busy   <= r_running;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_busy, r_m_pins};
    assign m_axis_tuser  = r_m_status;

`ifndef SYNTH
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one pass token in the cell chain");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tok == '0))
        else $error("pass token still moving while idle");

    a_tick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_action == ACT_TICK) |-> (r_status == ST_OK))
        else $error("tick beat carries a nonzero status");

    a_pass_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS_GO) |-> r_running)
        else $error("pass started with the ticker stopped");

    a_reset_stops: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_running && !r_m_valid))
        else $error("ticker or result alive after reset");
`endif

endmodule
